FILE: rtl/tfc_pkg.sv
// Package with the types, codes, reset values and helpers of the thermal fan controller.
`timescale 1ns / 1ps

package tfc_pkg;

   // Operation codes carried by an input item.
   typedef enum logic [2:0] {
      OP_TICK     = 3'd0,
      OP_SAMPLE   = 3'd1,
      OP_MEDIA    = 3'd2,
      OP_INSERTED = 3'd3,
      OP_REMOVED  = 3'd4,
      OP_EJECT    = 3'd5
   } op_type;

   // Fan modes.
   typedef enum logic [2:0] {
      MODE_IDLE     = 3'd0,
      MODE_STARTING = 3'd1,
      MODE_NORMAL   = 3'd2,
      MODE_RAMPING  = 3'd3,
      MODE_FULL     = 3'd4
   } mode_type;

   // Thermal phases.
   typedef enum logic [1:0] {
      PHASE_ABSENT  = 2'd0,
      PHASE_COOL    = 2'd1,
      PHASE_HOT     = 2'd2,
      PHASE_INITIAL = 2'd3
   } phase_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_SERVICE_PERIOD = 3'd0,
      CSR_START_DELAY    = 3'd1,
      CSR_RAMP_INTERVAL  = 3'd2,
      CSR_RAMP_STEP      = 3'd3,
      CSR_NORMAL_DUTY    = 3'd4,
      CSR_HOT_MINIMUM    = 3'd5,
      CSR_COOL_MAXIMUM   = 3'd6,
      CSR_FAN_OFF        = 3'd7
   } csr_index_type;

   localparam int unsigned CSR_DATA_W = 24;

   // Configuration reset values.
   localparam logic [15:0] SERVICE_PERIOD_RST = 16'd800;
   localparam logic [15:0] START_DELAY_RST    = 16'd100;
   localparam logic [23:0] RAMP_INTERVAL_RST  = 24'd60000;
   localparam logic [6:0]  RAMP_STEP_RST      = 7'd13;
   localparam logic [6:0]  NORMAL_DUTY_RST    = 7'd50;
   localparam logic [7:0]  HOT_MINIMUM_RST    = 8'd45;
   localparam logic [7:0]  COOL_MAXIMUM_RST   = 8'd40;

   // Fixed values of the datapath.
   localparam logic [6:0] DUTY_RST      = 7'd10;
   localparam logic [6:0] DUTY_MAX      = 7'd100;
   localparam logic [6:0] DUTY_FULL_MIN = 7'd99;
   localparam logic [7:0] TEMP_NONE     = 8'hFF;

   // Default number of hot readings counted before the hot phase is set.
   localparam int unsigned HOT_CONFIRMATIONS_DEF = 3;

   // Clamp a duty value to 100 percent.
   function automatic logic [6:0] clamp_duty(input logic [7:0] duty);
      logic [6:0] res;
      res = (duty > {1'b0, DUTY_MAX}) ? DUTY_MAX : duty[6:0];
      return res;
   endfunction

   // Wrap-safe deadline check: reached when (now - due) is not negative.
   function automatic logic deadline_reached(input logic [31:0] now, input logic [31:0] due);
      logic [31:0] diff;
      diff = now - due;
      return ~diff[31];
   endfunction

endpackage

FILE: rtl/thermal_fan_controller_top.sv
// Thermal fan controller: hysteresis phase tracking and fan duty sequencing.
// Throughput: one item per cycle while the output is not stalled. The input register feeds
// one pass of compare-and-add logic whose outcome is written to the state and the result
// register in the same cycle; an accepted item thus passes the input and result registers.
// Reset is synchronous and active high; it restores the register defaults, idle mode,
// absent phase, duty 10 and empties both stages.
`timescale 1ns / 1ps

module thermal_fan_controller_top #(
   parameter int unsigned HotConfirmations = tfc_pkg::HOT_CONFIRMATIONS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Input items
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [2:0]                      req_operation,
   input  logic [31:0]                     req_now_ms,
   input  logic                            req_sample_ok,
   input  logic [7:0]                      req_sample_celsius,
   // Result items
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [6:0]                      rsp_duty_percent,
   output logic [2:0]                      rsp_fan_mode,
   output logic [1:0]                      rsp_phase,
   output logic [7:0]                      rsp_last_temperature,
   output logic [1:0]                      rsp_hot_confirm_count,
   // Configuration writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [2:0]                      csr_index,
   input  logic [tfc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int unsigned CntW = (HotConfirmations < 2) ? 1 : $clog2(HotConfirmations + 1);
   localparam logic [CntW-1:0] CntFull = CntW'(HotConfirmations);

   // Configuration registers
   logic [15:0] service_period_ff;
   logic [15:0] start_delay_ff;
   logic [23:0] ramp_interval_ff;
   logic [6:0]  ramp_step_ff;
   logic [6:0]  normal_duty_ff;
   logic [7:0]  hot_minimum_ff;
   logic [7:0]  cool_maximum_ff;
   logic        fan_off_ff;

   // Input stage
   logic                 s1_valid_ff;
   tfc_pkg::op_type      s1_op_ff;
   logic [31:0]          s1_now_ff;
   logic                 s1_ok_ff;
   logic [7:0]           s1_celsius_ff;

   // Controller state
   tfc_pkg::mode_type    mode_ff, mode_in;
   tfc_pkg::phase_type   phase_ff, phase_in;
   logic [6:0]           duty_ff, duty_in;
   logic [CntW-1:0]      hot_cnt_ff, hot_cnt_in;
   logic [7:0]           temp_ff, temp_in;
   logic [31:0]          service_due_ff, service_due_in;
   logic [31:0]          action_due_ff, action_due_in;

   // Result register
   logic                 rsp_valid_ff;
   logic [6:0]           rsp_duty_ff;
   tfc_pkg::mode_type    rsp_mode_ff;
   tfc_pkg::phase_type   rsp_phase_ff;
   logic [7:0]           rsp_temp_ff;
   logic [1:0]           rsp_cnt_ff;

   logic        advance;
   logic        csr_write;
   logic        tick_fire;
   logic        action_reached;
   logic [31:0] cnt_wide;

   // The input stage moves on whenever the result register is free or being emptied.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   assign tick_fire = advance && (s1_op_ff == tfc_pkg::OP_TICK) && !fan_off_ff
                      && tfc_pkg::deadline_reached(s1_now_ff, service_due_ff);
   assign action_reached = tfc_pkg::deadline_reached(s1_now_ff, action_due_ff);

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         service_period_ff <= tfc_pkg::SERVICE_PERIOD_RST;
         start_delay_ff    <= tfc_pkg::START_DELAY_RST;
         ramp_interval_ff  <= tfc_pkg::RAMP_INTERVAL_RST;
         ramp_step_ff      <= tfc_pkg::RAMP_STEP_RST;
         normal_duty_ff    <= tfc_pkg::NORMAL_DUTY_RST;
         hot_minimum_ff    <= tfc_pkg::HOT_MINIMUM_RST;
         cool_maximum_ff   <= tfc_pkg::COOL_MAXIMUM_RST;
         fan_off_ff        <= 1'b0;
      end else if (csr_write) begin
         case (tfc_pkg::csr_index_type'(csr_index))
            tfc_pkg::CSR_SERVICE_PERIOD: service_period_ff <= csr_wdata[15:0];
            tfc_pkg::CSR_START_DELAY:    start_delay_ff    <= csr_wdata[15:0];
            tfc_pkg::CSR_RAMP_INTERVAL:  ramp_interval_ff  <= csr_wdata[23:0];
            tfc_pkg::CSR_RAMP_STEP:      ramp_step_ff      <= csr_wdata[6:0];
            tfc_pkg::CSR_NORMAL_DUTY:    normal_duty_ff    <= csr_wdata[6:0];
            tfc_pkg::CSR_HOT_MINIMUM:    hot_minimum_ff    <= csr_wdata[7:0];
            tfc_pkg::CSR_COOL_MAXIMUM:   cool_maximum_ff   <= csr_wdata[7:0];
            tfc_pkg::CSR_FAN_OFF:        fan_off_ff        <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_op_ff      <= tfc_pkg::op_type'(req_operation);
         s1_now_ff     <= req_now_ms;
         s1_ok_ff      <= req_sample_ok;
         s1_celsius_ff <= req_sample_celsius;
      end
   end

   // Next fan mode.
   always_comb begin
      mode_in = mode_ff;
      if (advance && s1_op_ff == tfc_pkg::OP_EJECT) begin
         mode_in = tfc_pkg::MODE_IDLE;
      end else if (tick_fire) begin
         if (phase_ff == tfc_pkg::PHASE_ABSENT) begin
            mode_in = tfc_pkg::MODE_IDLE;
         end else begin
            case (mode_ff)
               tfc_pkg::MODE_IDLE: begin
                  if (phase_ff inside {tfc_pkg::PHASE_COOL, tfc_pkg::PHASE_HOT}) begin
                     mode_in = tfc_pkg::MODE_STARTING;
                  end
               end
               tfc_pkg::MODE_STARTING: begin
                  if (action_reached) begin
                     mode_in = tfc_pkg::MODE_NORMAL;
                  end
               end
               tfc_pkg::MODE_NORMAL: begin
                  if (phase_ff == tfc_pkg::PHASE_HOT) begin
                     mode_in = tfc_pkg::MODE_RAMPING;
                  end
               end
               tfc_pkg::MODE_RAMPING: begin
                  if (action_reached && duty_ff > tfc_pkg::DUTY_FULL_MIN) begin
                     mode_in = tfc_pkg::MODE_FULL;
                  end
               end
               tfc_pkg::MODE_FULL: begin
                  if (phase_ff == tfc_pkg::PHASE_COOL) begin
                     mode_in = tfc_pkg::MODE_NORMAL;
                  end
               end
               default: mode_in = tfc_pkg::MODE_IDLE;
            endcase
         end
      end
   end

   // Duty and deadlines on service ticks, teardown and fan-off writes.
   always_comb begin
      duty_in        = duty_ff;
      service_due_in = service_due_ff;
      action_due_in  = action_due_ff;
      if (advance && s1_op_ff == tfc_pkg::OP_EJECT) begin
         duty_in = '0;
      end else if (tick_fire) begin
         service_due_in = s1_now_ff + {16'd0, service_period_ff};
         if (phase_ff == tfc_pkg::PHASE_ABSENT) begin
            duty_in = '0;
         end else begin
            case (mode_ff)
               tfc_pkg::MODE_IDLE: begin
                  if (phase_ff inside {tfc_pkg::PHASE_COOL, tfc_pkg::PHASE_HOT}) begin
                     action_due_in = s1_now_ff + {16'd0, start_delay_ff};
                  end
               end
               tfc_pkg::MODE_STARTING: begin
                  if (action_reached) begin
                     duty_in = tfc_pkg::clamp_duty({1'b0, normal_duty_ff});
                  end
               end
               tfc_pkg::MODE_NORMAL: begin
                  if (phase_ff == tfc_pkg::PHASE_HOT) begin
                     action_due_in = s1_now_ff;
                  end
               end
               tfc_pkg::MODE_RAMPING: begin
                  if (action_reached && duty_ff <= tfc_pkg::DUTY_FULL_MIN) begin
                     duty_in = tfc_pkg::clamp_duty({1'b0, duty_ff} + {1'b0, ramp_step_ff});
                     action_due_in = s1_now_ff + {8'd0, ramp_interval_ff};
                  end
               end
               tfc_pkg::MODE_FULL: begin
                  if (phase_ff == tfc_pkg::PHASE_COOL) begin
                     duty_in = tfc_pkg::clamp_duty({1'b0, normal_duty_ff});
                  end
               end
               default: duty_in = '0;
            endcase
         end
      end
      // Switching the fan off forces the duty to zero.
      if (csr_write && tfc_pkg::csr_index_type'(csr_index) == tfc_pkg::CSR_FAN_OFF
          && csr_wdata[0]) begin
         duty_in = '0;
      end
   end

   // Phase, confirmation count and temperature from samples and media events.
   always_comb begin
      phase_in   = phase_ff;
      hot_cnt_in = hot_cnt_ff;
      temp_in    = temp_ff;
      if (advance) begin
         case (s1_op_ff)
            tfc_pkg::OP_SAMPLE: begin
               if (!s1_ok_ff) begin
                  temp_in = tfc_pkg::TEMP_NONE;
               end else begin
                  temp_in = s1_celsius_ff;
                  if (s1_celsius_ff >= hot_minimum_ff) begin
                     if (hot_cnt_ff < CntFull) begin
                        hot_cnt_in = hot_cnt_ff + CntW'(1);
                     end else begin
                        phase_in = tfc_pkg::PHASE_HOT;
                     end
                  end else begin
                     hot_cnt_in = CntFull;
                     if (s1_celsius_ff <= cool_maximum_ff) begin
                        phase_in = tfc_pkg::PHASE_COOL;
                     end
                  end
               end
            end
            tfc_pkg::OP_MEDIA: begin
               phase_in   = tfc_pkg::PHASE_COOL;
               temp_in    = tfc_pkg::TEMP_NONE;
               hot_cnt_in = '0;
            end
            tfc_pkg::OP_INSERTED: begin
               phase_in   = tfc_pkg::PHASE_INITIAL;
               temp_in    = tfc_pkg::TEMP_NONE;
               hot_cnt_in = '0;
            end
            tfc_pkg::OP_REMOVED: begin
               phase_in   = tfc_pkg::PHASE_ABSENT;
               temp_in    = tfc_pkg::TEMP_NONE;
               hot_cnt_in = '0;
            end
            tfc_pkg::OP_EJECT: begin
               phase_in = tfc_pkg::PHASE_ABSENT;
               temp_in  = tfc_pkg::TEMP_NONE;
            end
            default: ;
         endcase
      end
   end

   // Controller state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= tfc_pkg::MODE_IDLE;
         phase_ff       <= tfc_pkg::PHASE_ABSENT;
         duty_ff        <= tfc_pkg::DUTY_RST;
         hot_cnt_ff     <= '0;
         temp_ff        <= tfc_pkg::TEMP_NONE;
         service_due_ff <= '0;
         action_due_ff  <= '0;
      end else begin
         mode_ff        <= mode_in;
         phase_ff       <= phase_in;
         duty_ff        <= duty_in;
         hot_cnt_ff     <= hot_cnt_in;
         temp_ff        <= temp_in;
         service_due_ff <= service_due_in;
         action_due_ff  <= action_due_in;
      end
   end

   // The count is shown by its low two bits.
   assign cnt_wide = 32'(hot_cnt_in);

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_duty_ff  <= duty_in;
         rsp_mode_ff  <= mode_in;
         rsp_phase_ff <= phase_in;
         rsp_temp_ff  <= temp_in;
         rsp_cnt_ff   <= cnt_wide[1:0];
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_duty_percent      = rsp_duty_ff;
   assign rsp_fan_mode          = rsp_mode_ff;
   assign rsp_phase             = rsp_phase_ff;
   assign rsp_last_temperature  = rsp_temp_ff;
   assign rsp_hot_confirm_count = rsp_cnt_ff;

endmodule

FILE: rtl/tfc_checker.sv
// Port-level checker for the thermal fan controller and its bind to the top level.
`timescale 1ns / 1ps

module tfc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [6:0]                      rsp_duty_percent,
   input logic [2:0]                      rsp_fan_mode,
   input logic [1:0]                      rsp_phase,
   input logic [7:0]                      rsp_last_temperature,
   input logic [1:0]                      rsp_hot_confirm_count
);

   // A stalled result item stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item withdrawn while stalled");

   // With the output side empty the block always has room for a new item.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled although no result is pending");

   // Every duty shown is clamped to full scale.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_duty_percent <= tfc_pkg::DUTY_MAX)
      else $error("duty above full scale");

   // Leaving reset, no result item is offered.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result item offered straight after reset");

   // A stalled item keeps its payload (fields checked together).
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_fan_mode) && $stable(rsp_phase)
         && $stable(rsp_last_temperature) && $stable(rsp_hot_confirm_count)
         && $stable(rsp_duty_percent))
      else $error("stalled result payload changed");

endmodule

bind thermal_fan_controller_top tfc_checker u_tfc_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_ready             (req_ready),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_duty_percent      (rsp_duty_percent),
   .rsp_fan_mode          (rsp_fan_mode),
   .rsp_phase             (rsp_phase),
   .rsp_last_temperature  (rsp_last_temperature),
   .rsp_hot_confirm_count (rsp_hot_confirm_count)
);

FILE: sim/thermal_fan_controller_top_test.sv
// Self-checking testbench for the thermal fan controller: directed and random items under idling.
`timescale 1ns / 1ps

module thermal_fan_controller_top_test;

   // Operation codes that the block does not use.
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam int unsigned HOT_LIMIT = tfc_pkg::HOT_CONFIRMATIONS_DEF;
   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned ITEMS_PER_STRETCH = 30;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] now_ms;
      logic        ok;
      logic [7:0]  celsius;
   } fan_item_type;

   typedef struct packed {
      logic [6:0] duty;
      logic [2:0] mode;
      logic [1:0] phase;
      logic [7:0] temp;
      logic [1:0] hot_count;
   } fan_status_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_operation = '0;
   logic [31:0] req_now_ms = '0;
   logic        req_sample_ok = 1'b0;
   logic [7:0]  req_sample_celsius = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [6:0]  rsp_duty_percent;
   logic [2:0]  rsp_fan_mode;
   logic [1:0]  rsp_phase;
   logic [7:0]  rsp_last_temperature;
   logic [1:0]  rsp_hot_confirm_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [tfc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // Items waiting to be driven and results waiting to be seen.
   fan_item_type   pending_items[$];
   fan_status_type expected_status[$];

   int unsigned fail_count = 0;
   int unsigned idle_cycles = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;

   // Settings known to the item generator.
   int unsigned gen_service;
   int unsigned gen_ramp;
   int unsigned gen_hot;
   int unsigned gen_cool;
   logic [31:0] wall_ms;

   // Predicted configuration and state of the controller.
   logic [15:0]         m_service;
   logic [15:0]         m_start;
   logic [23:0]         m_ramp;
   logic [6:0]          m_step;
   logic [6:0]          m_normal;
   logic [7:0]          m_hot_min;
   logic [7:0]          m_cool_max;
   logic                m_fan_off;
   tfc_pkg::mode_type   m_mode;
   tfc_pkg::phase_type  m_phase;
   logic [6:0]          m_duty;
   int unsigned         m_hot_count;
   logic [7:0]          m_temp;
   logic [31:0]         m_service_due;
   logic [31:0]         m_action_due;

   thermal_fan_controller_top DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_operation         (req_operation),
      .req_now_ms            (req_now_ms),
      .req_sample_ok         (req_sample_ok),
      .req_sample_celsius    (req_sample_celsius),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_duty_percent      (rsp_duty_percent),
      .rsp_fan_mode          (rsp_fan_mode),
      .rsp_phase             (rsp_phase),
      .rsp_last_temperature  (rsp_last_temperature),
      .rsp_hot_confirm_count (rsp_hot_confirm_count),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // A deadline is due once the wrapped distance to it is not negative.
   function automatic logic is_due(input logic [31:0] now, input logic [31:0] due);
      logic [31:0] gap;
      gap = now - due;
      return ~gap[31];
   endfunction

   function automatic logic [6:0] limit_duty(input int unsigned d);
      return (d > 100) ? 7'd100 : d[6:0];
   endfunction

   // Configuration write as the controller sees it.
   task automatic apply_setting(input logic [2:0] idx,
                                input logic [tfc_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         tfc_pkg::CSR_SERVICE_PERIOD: m_service = data[15:0];
         tfc_pkg::CSR_START_DELAY:    m_start = data[15:0];
         tfc_pkg::CSR_RAMP_INTERVAL:  m_ramp = data[23:0];
         tfc_pkg::CSR_RAMP_STEP:      m_step = data[6:0];
         tfc_pkg::CSR_NORMAL_DUTY:    m_normal = data[6:0];
         tfc_pkg::CSR_HOT_MINIMUM:    m_hot_min = data[7:0];
         tfc_pkg::CSR_COOL_MAXIMUM:   m_cool_max = data[7:0];
         tfc_pkg::CSR_FAN_OFF: begin
            m_fan_off = data[0];
            if (data[0]) m_duty = '0;
         end
         default: ;
      endcase
   endtask

   // Apply one item to the predicted state and return the status it leaves.
   function automatic fan_status_type advance_fan_model(input fan_item_type it);
      fan_status_type st;
      case (it.op)
         tfc_pkg::OP_TICK: begin
            if (!m_fan_off && is_due(it.now_ms, m_service_due)) begin
               m_service_due = it.now_ms + {16'd0, m_service};
               if (m_phase == tfc_pkg::PHASE_ABSENT) begin
                  m_duty = '0;
                  m_mode = tfc_pkg::MODE_IDLE;
               end else begin
                  case (m_mode)
                     tfc_pkg::MODE_IDLE: begin
                        if (m_phase inside {tfc_pkg::PHASE_COOL, tfc_pkg::PHASE_HOT}) begin
                           m_action_due = it.now_ms + {16'd0, m_start};
                           m_mode = tfc_pkg::MODE_STARTING;
                        end
                     end
                     tfc_pkg::MODE_STARTING: begin
                        if (is_due(it.now_ms, m_action_due)) begin
                           m_duty = limit_duty(m_normal);
                           m_mode = tfc_pkg::MODE_NORMAL;
                        end
                     end
                     tfc_pkg::MODE_NORMAL: begin
                        if (m_phase == tfc_pkg::PHASE_HOT) begin
                           m_action_due = it.now_ms;
                           m_mode = tfc_pkg::MODE_RAMPING;
                        end
                     end
                     tfc_pkg::MODE_RAMPING: begin
                        if (is_due(it.now_ms, m_action_due)) begin
                           if (m_duty > 7'd99) begin
                              m_mode = tfc_pkg::MODE_FULL;
                           end else begin
                              m_duty = limit_duty(int'(m_duty) + int'(m_step));
                              m_action_due = it.now_ms + {8'd0, m_ramp};
                           end
                        end
                     end
                     tfc_pkg::MODE_FULL: begin
                        if (m_phase == tfc_pkg::PHASE_COOL) begin
                           m_duty = limit_duty(m_normal);
                           m_mode = tfc_pkg::MODE_NORMAL;
                        end
                     end
                     default: begin
                        m_duty = '0;
                        m_mode = tfc_pkg::MODE_IDLE;
                     end
                  endcase
               end
            end
         end
         tfc_pkg::OP_SAMPLE: begin
            if (!it.ok) begin
               m_temp = tfc_pkg::TEMP_NONE;
            end else begin
               m_temp = it.celsius;
               if (it.celsius >= m_hot_min) begin
                  if (m_hot_count < HOT_LIMIT) m_hot_count++;
                  else m_phase = tfc_pkg::PHASE_HOT;
               end else begin
                  m_hot_count = HOT_LIMIT;
                  if (it.celsius <= m_cool_max) m_phase = tfc_pkg::PHASE_COOL;
               end
            end
         end
         tfc_pkg::OP_MEDIA, tfc_pkg::OP_INSERTED, tfc_pkg::OP_REMOVED: begin
            m_phase = (it.op == tfc_pkg::OP_MEDIA) ? tfc_pkg::PHASE_COOL :
                      (it.op == tfc_pkg::OP_INSERTED) ? tfc_pkg::PHASE_INITIAL :
                      tfc_pkg::PHASE_ABSENT;
            m_temp = tfc_pkg::TEMP_NONE;
            m_hot_count = 0;
         end
         tfc_pkg::OP_EJECT: begin
            m_temp = tfc_pkg::TEMP_NONE;
            m_phase = tfc_pkg::PHASE_ABSENT;
            m_duty = '0;
            m_mode = tfc_pkg::MODE_IDLE;
         end
         default: ;
      endcase
      st.duty = m_duty;
      st.mode = m_mode;
      st.phase = m_phase;
      st.temp = m_temp;
      st.hot_count = m_hot_count[1:0];
      return st;
   endfunction

   // Driver: presents queued items and predicts each one as it is accepted.
   always @(posedge clock) begin
      fan_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         m_service = tfc_pkg::SERVICE_PERIOD_RST;
         m_start = tfc_pkg::START_DELAY_RST;
         m_ramp = tfc_pkg::RAMP_INTERVAL_RST;
         m_step = tfc_pkg::RAMP_STEP_RST;
         m_normal = tfc_pkg::NORMAL_DUTY_RST;
         m_hot_min = tfc_pkg::HOT_MINIMUM_RST;
         m_cool_max = tfc_pkg::COOL_MAXIMUM_RST;
         m_fan_off = 1'b0;
         m_mode = tfc_pkg::MODE_IDLE;
         m_phase = tfc_pkg::PHASE_ABSENT;
         m_duty = tfc_pkg::DUTY_RST;
         m_hot_count = 0;
         m_temp = tfc_pkg::TEMP_NONE;
         m_service_due = '0;
         m_action_due = '0;
      end else begin
         if (csr_valid && csr_ready) apply_setting(csr_index, csr_wdata);
         if (req_valid && req_ready) begin
            expected_status.push_back(advance_fan_model(
               {req_operation, req_now_ms, req_sample_ok, req_sample_celsius}));
         end
         if (!req_valid || req_ready) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               nxt = pending_items.pop_front();
               req_valid <= 1'b1;
               req_operation <= nxt.op;
               req_now_ms <= nxt.now_ms;
               req_sample_ok <= nxt.ok;
               req_sample_celsius <= nxt.celsius;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Monitor: stalls the result channel and compares each result item.
   always @(posedge clock) begin
      fan_status_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_status.size() == 0) begin
               $error("result item with no expectation waiting");
               fail_count++;
            end else begin
               want = expected_status.pop_front();
               check_field("duty_percent", want.duty, rsp_duty_percent);
               check_field("fan_mode", want.mode, rsp_fan_mode);
               check_field("phase", want.phase, rsp_phase);
               check_field("last_temperature", want.temp, rsp_last_temperature);
               check_field("hot_confirm_count", want.hot_count, rsp_hot_confirm_count);
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Watchdog on cycles in which no handshake completes.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic queue_item(input logic [2:0] op, input logic [31:0] now,
                             input logic ok, input logic [7:0] celsius);
      pending_items.push_back({op, now, ok, celsius});
   endtask

   // Random item, mostly ticks on an advancing clock and samples near the thresholds.
   function automatic fan_item_type random_item();
      fan_item_type it;
      int unsigned pick;
      int unsigned t;
      pick = $urandom_range(0, 99);
      if (pick < 2) wall_ms += $urandom;
      else if (pick < 12) wall_ms += $urandom_range(0, (gen_ramp > 100000) ? 100000 : gen_ramp);
      else wall_ms += $urandom_range(0, 2 * gen_service + 2);
      it.now_ms = $urandom;
      it.ok = ($urandom_range(0, 9) != 0);
      it.celsius = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         it.op = tfc_pkg::OP_TICK;
         it.now_ms = wall_ms;
      end else if (pick < 80) begin
         it.op = tfc_pkg::OP_SAMPLE;
         case ($urandom_range(0, 3))
            0: t = $urandom_range(0, 255);
            1, 2: t = gen_hot + $urandom_range(0, 8);
            default: t = (gen_cool > 5) ? gen_cool - $urandom_range(0, 5)
                                        : $urandom_range(0, gen_cool);
         endcase
         it.celsius = (t > 255) ? 8'd255 : t[7:0];
      end else if (pick < 86) begin
         it.op = tfc_pkg::OP_MEDIA;
      end else if (pick < 90) begin
         it.op = tfc_pkg::OP_INSERTED;
      end else if (pick < 93) begin
         it.op = tfc_pkg::OP_REMOVED;
      end else if (pick < 95) begin
         it.op = tfc_pkg::OP_EJECT;
      end else if (pick < 97) begin
         it.op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
      end else begin
         it.op = 3'($urandom_range(0, 7));
         it.now_ms = wall_ms;
      end
      return it;
   endfunction

   task automatic write_reg(input tfc_pkg::csr_index_type idx,
                            input logic [tfc_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Writes every register; bits above each register's width carry noise.
   task automatic program_fan(input logic [15:0] svc, input logic [15:0] start,
                              input logic [23:0] ramp, input logic [6:0] step,
                              input logic [6:0] normal, input logic [7:0] hot,
                              input logic [7:0] cool, input logic off);
      gen_service = svc;
      gen_ramp = ramp;
      gen_hot = hot;
      gen_cool = cool;
      write_reg(tfc_pkg::CSR_SERVICE_PERIOD, {8'($urandom), svc});
      write_reg(tfc_pkg::CSR_START_DELAY, {8'($urandom), start});
      write_reg(tfc_pkg::CSR_RAMP_INTERVAL, ramp);
      write_reg(tfc_pkg::CSR_RAMP_STEP, {17'($urandom), step});
      write_reg(tfc_pkg::CSR_NORMAL_DUTY, {17'($urandom), normal});
      write_reg(tfc_pkg::CSR_HOT_MINIMUM, {16'($urandom), hot});
      write_reg(tfc_pkg::CSR_COOL_MAXIMUM, {16'($urandom), cool});
      write_reg(tfc_pkg::CSR_FAN_OFF, {23'($urandom), off});
   endtask

   // Wait until every item is accepted and every result has arrived.
   // The check runs at the falling edge so that it sees settled handshakes.
   task automatic wait_drained();
      while (pending_items.size() != 0 || req_valid || expected_status.size() != 0)
         @(negedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Stimulus sequence.
   initial begin
      int unsigned hot;
      gen_service = tfc_pkg::SERVICE_PERIOD_RST;
      gen_ramp = tfc_pkg::RAMP_INTERVAL_RST;
      gen_hot = tfc_pkg::HOT_MINIMUM_RST;
      gen_cool = tfc_pkg::COOL_MAXIMUM_RST;
      wall_ms = 32'd5000;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed walk through the fan sequence with the reset settings.
      queue_item(OP_SPARE_LO, 32'd0, 1'b1, 8'd0);
      queue_item(OP_SPARE_HI, 32'hFFFF_FFFF, 1'b1, 8'hFF);
      queue_item(tfc_pkg::OP_TICK, 32'd0, 1'b0, 8'd0);
      queue_item(tfc_pkg::OP_SAMPLE, 32'd0, 1'b0, 8'd30);
      // A reading of 255 is stored as unavailable but still counts as hot.
      queue_item(tfc_pkg::OP_SAMPLE, 32'd0, 1'b1, 8'd255);
      queue_item(tfc_pkg::OP_INSERTED, 32'd0, 1'b0, 8'd0);
      queue_item(tfc_pkg::OP_SAMPLE, 32'd0, 1'b1, 8'd0);
      queue_item(tfc_pkg::OP_MEDIA, 32'd0, 1'b0, 8'd0);
      queue_item(tfc_pkg::OP_TICK, 32'd800, 1'b0, 8'd0);
      queue_item(tfc_pkg::OP_TICK, 32'd1600, 1'b0, 8'd0);
      repeat (4) queue_item(tfc_pkg::OP_SAMPLE, 32'd0, 1'b1, 8'd254);
      queue_item(tfc_pkg::OP_SAMPLE, 32'd0, 1'b1, 8'd44);
      queue_item(tfc_pkg::OP_SAMPLE, 32'd0, 1'b1, 8'd254);
      queue_item(tfc_pkg::OP_TICK, 32'd2400, 1'b0, 8'd0);
      queue_item(tfc_pkg::OP_TICK, 32'd3200, 1'b0, 8'd0);
      // A counter value that lies far behind the deadline is not yet due.
      queue_item(tfc_pkg::OP_TICK, 32'hFFFF_FFFF, 1'b0, 8'd0);
      queue_item(tfc_pkg::OP_REMOVED, 32'd0, 1'b0, 8'd0);
      queue_item(tfc_pkg::OP_TICK, 32'h7FFF_FFFF, 1'b0, 8'd0);
      queue_item(tfc_pkg::OP_EJECT, 32'd0, 1'b0, 8'd0);
      queue_item(tfc_pkg::OP_SAMPLE, 32'hAAAA_5555, 1'b1, 8'h55);
      wait_drained();

      // Random phases, each with its own register settings and all idling patterns.
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: program_fan(16'd1, 16'd0, 24'd1, 7'd100, 7'd100, 8'd0, 8'd0, 1'b0);
            1: program_fan(16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 7'd1, 7'd0, 8'd254, 8'd254, 1'b0);
            2: begin
               hot = $urandom_range(30, 60);
               program_fan(16'($urandom_range(1, 40)), 16'($urandom_range(0, 60)),
                           24'($urandom_range(1, 100)), 7'($urandom_range(1, 30)),
                           7'($urandom_range(0, 100)), 8'(hot),
                           8'(hot - $urandom_range(0, 10)), 1'b1);
            end
            3: begin
               // Zero step with an over-range normal duty; the clock crosses its wrap.
               wall_ms = 32'hFFFF_FF00;
               program_fan(16'($urandom_range(0, 20)), 16'd20, 24'd10, 7'd0, 7'd127,
                           8'd255, 8'd255, 1'b0);
            end
            default: begin
               hot = $urandom_range(20, 80);
               program_fan(16'($urandom_range(1, 40)), 16'($urandom_range(0, 60)),
                           24'($urandom_range(1, 100)), 7'($urandom_range(1, 40)),
                           7'($urandom_range(0, 127)), 8'(hot),
                           8'(hot - $urandom_range(0, 15)), 1'b0);
            end
         endcase
         for (int k = 0; k < 4; k++) begin
            case (k)
               0: begin send_idle_pct = 0; rsp_stall_pct = 0; end
               1: begin send_idle_pct = 63; rsp_stall_pct = 0; end
               2: begin send_idle_pct = 0; rsp_stall_pct = 63; end
               default: begin send_idle_pct = 27; rsp_stall_pct = 27; end
            endcase
            repeat (ITEMS_PER_STRETCH) pending_items.push_back(random_item());
            while (pending_items.size() != 0) @(posedge clock);
         end
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (fail_count == 0 && expected_status.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
